// File: sv/annexb_nal_unit_splitter_macros.svh
// ----------------------------------------------------------------------------
// annexb nal unit splitter assertion macros
// shared concurrent assertion wrappers, clocked on clk, off during reset
// ----------------------------------------------------------------------------
`ifndef ANNEXB_NAL_UNIT_SPLITTER_MACROS_SVH
`define ANNEXB_NAL_UNIT_SPLITTER_MACROS_SVH

// same-cycle implication
`define ANX_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ANX_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/anx_pkg.sv
// ----------------------------------------------------------------------------
// anx_pkg
// types and constants shared by the annex b nal splitter front and back
// ----------------------------------------------------------------------------
package anx_pkg;

  localparam int MAX_RES = 5;                  // results one byte can cause
  localparam int QDEPTH  = 8;                  // result queue entries
  localparam int QAW     = $clog2(QDEPTH);
  localparam int QCW     = $clog2(QDEPTH + 1);
  localparam int NW      = $clog2(MAX_RES + 1);

  localparam logic CODEC_H264 = 1'b0;
  localparam logic CODEC_H265 = 1'b1;

  localparam logic [5:0] H264_TYPE_MASK = 6'h1f;
  localparam logic [5:0] H265_TYPE_MASK = 6'h3f;

  localparam logic [2:0] SC_LEN3 = 3'd3;
  localparam logic [2:0] SC_LEN4 = 3'd4;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       len4;
    logic       hdr;
    logic       pend;
    logic       rlast;
  } ent_t;

  typedef struct packed {
    logic                       valid;
    logic [NW-1:0]              n;
    ent_t [MAX_RES-1:0]         ents;
  } push_t;

  function automatic ent_t mk_ent(logic [7:0] data, logic first, logic len4, logic hdr);
    ent_t e;
    e.data  = data;
    e.first = first;
    e.len4  = len4;
    e.hdr   = hdr;
    e.pend  = 1'b0;
    e.rlast = 1'b0;
    return e;
  endfunction

endpackage

// File: sv/anx_front.sv
// ----------------------------------------------------------------------------
// anx_front
// lookahead window and start code classifier; turns each accepted byte into
// a group of up to five result entries for the queue
// ----------------------------------------------------------------------------
module anx_front import anx_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output push_t      push
);

  logic [3:0][7:0]    win_r, win_nxt;
  logic [2:0]         cnt_r, cnt_nxt;
  logic               in_nal_r, in_nal_nxt;
  logic               hdr_pend_r, hdr_pend_nxt;

  ent_t [MAX_RES-1:0] ents;
  logic [NW-1:0]      n;
  logic               sc;
  logic [1:0]         s;
  logic               len4;

  always_comb begin
    win_nxt      = win_r;
    cnt_nxt      = cnt_r;
    in_nal_nxt   = in_nal_r;
    hdr_pend_nxt = hdr_pend_r;
    ents         = '0;
    n            = '0;
    s            = 2'd0;
    len4         = 1'b0;

    case (cnt_r)
      3'd3:    sc = (win_r[0] == 8'h00) && (win_r[1] == 8'h00) && (win_r[2] == 8'h01);
      3'd4:    sc = (win_r[1] == 8'h00) && (win_r[2] == 8'h00) && (win_r[3] == 8'h01);
      default: sc = 1'b0;
    endcase

    if (sc) begin
      s = (cnt_r == 3'd4) ? 2'd1 : 2'd0;
      if ((cnt_r == 3'd4) && (win_r[0] == 8'h00)) begin
        s    = 2'd0;
        len4 = 1'b1;
      end
      for (int i = 0; i < 4; i++) begin
        if (3'(i) < cnt_nxt) begin
          // bytes ahead of the code only go out if a nal is already open
          if ((2'(i) >= s) || in_nal_nxt) begin
            ents[n] = mk_ent(win_nxt[i], 2'(i) == s, len4, hdr_pend_nxt);
            n       = n + NW'(1);
          end
          hdr_pend_nxt = 1'b0;
        end
      end
      in_nal_nxt   = 1'b1;
      win_nxt      = '0;
      win_nxt[0]   = in_byte;
      cnt_nxt      = 3'd1;
      hdr_pend_nxt = 1'b1;
    end else begin
      if (cnt_r == 3'd4) begin
        if (in_nal_nxt) begin
          ents[n] = mk_ent(win_nxt[0], 1'b0, 1'b0, hdr_pend_nxt);
          n       = n + NW'(1);
        end
        hdr_pend_nxt = 1'b0;
        win_nxt      = {8'h00, win_nxt[3:1]};
        cnt_nxt      = 3'd3;
      end
      win_nxt[cnt_nxt[1:0]] = in_byte;
      cnt_nxt               = cnt_nxt + 3'd1;
    end

    // end of packet: flush whatever is left in the window
    if (in_last) begin
      for (int i = 0; i < 4; i++) begin
        if (3'(i) < cnt_nxt) begin
          if (in_nal_nxt) begin
            ents[n] = mk_ent(win_nxt[i], 1'b0, 1'b0, hdr_pend_nxt);
            n       = n + NW'(1);
          end
          hdr_pend_nxt = 1'b0;
        end
      end
      win_nxt      = '0;
      cnt_nxt      = 3'd0;
      in_nal_nxt   = 1'b0;
      hdr_pend_nxt = 1'b0;
    end

    if (n != '0) begin
      ents[n - NW'(1)].rlast = 1'b1;
      ents[n - NW'(1)].pend  = in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r      <= '0;
      cnt_r      <= 3'd0;
      in_nal_r   <= 1'b0;
      hdr_pend_r <= 1'b0;
    end else if (accept) begin
      win_r      <= win_nxt;
      cnt_r      <= cnt_nxt;
      in_nal_r   <= in_nal_nxt;
      hdr_pend_r <= hdr_pend_nxt;
    end
  end

  assign push.valid = accept;
  assign push.n     = n;
  assign push.ents  = ents;

endmodule

// File: sv/anx_back.sv
// ----------------------------------------------------------------------------
// anx_back
// result queue: takes a group of entries per beat, plays them out one beat per
// cycle while out_tready is high, with nal type and start code length formatting
// ----------------------------------------------------------------------------
`include "annexb_nal_unit_splitter_macros.svh"

module anx_back import anx_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        codec_mode,
  input  push_t       push,
  output logic        room,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,   // out_byte[7:0], start_code_length[10:8], nal_type[16:11]
  output logic [2:0]  out_tuser,   // nal_first[0], header_flag[1], run_last[2]
  output logic        out_tlast    // packet_end
);

  ent_t           q_mem [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0] count_r, count_nxt;
  logic           pop;
  logic [QCW-1:0] push_n;
  ent_t           head;
  logic [5:0]     nal_type;
  logic [2:0]     sc_len;

  assign pop    = out_tvalid && out_tready;
  assign push_n = push.valid ? QCW'(push.n) : '0;
  assign room   = (count_r <= QCW'(QDEPTH - MAX_RES));

  assign wr_ptr_nxt = QAW'(wr_ptr_r + QAW'(push_n));
  assign rd_ptr_nxt = pop ? QAW'(rd_ptr_r + QAW'(1)) : rd_ptr_r;
  assign count_nxt  = QCW'(count_r + push_n - (pop ? QCW'(1) : QCW'(0)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      for (int k = 0; k < MAX_RES; k++) begin
        if (NW'(k) < push.n) begin
          q_mem[QAW'(wr_ptr_r + QAW'(k))] <= push.ents[k];
        end
      end
    end
  end

  assign head = q_mem[rd_ptr_r];

  always_comb begin
    if (!head.hdr) begin
      nal_type = '0;
    end else if (codec_mode == CODEC_H265) begin
      nal_type = 6'(head.data[7:1]) & H265_TYPE_MASK;
    end else begin
      nal_type = 6'(head.data) & H264_TYPE_MASK;
    end
    if (!head.first) begin
      sc_len = 3'd0;
    end else begin
      sc_len = head.len4 ? SC_LEN4 : SC_LEN3;
    end
  end

  assign out_tvalid = (count_r != '0);
  assign out_tdata  = {7'd0, nal_type, sc_len, head.data};
  assign out_tuser  = {head.rlast, head.hdr, head.first};
  assign out_tlast  = head.pend;

  `ANX_ASSERT_IMP(a_count_bound, 1'b1, count_r <= QCW'(QDEPTH), "queue count above depth")
  `ANX_ASSERT_IMP(a_no_overflow, push.valid,
                  ({1'b0, count_r} + (QCW+1)'(push.n)) <= (QCW+1)'(QDEPTH),
                  "queue overflow on push")
  `ANX_ASSERT_IMP(a_pend_is_run_last, out_tvalid && out_tlast, out_tuser[2],
                  "packet end beat is not the last beat of its run")
  `ANX_ASSERT_NXT(a_pop_drains, pop && !push.valid,
                  count_r == QCW'($past(count_r) - QCW'(1)),
                  "pop without push did not drain one entry")

endmodule

// File: sv/annexb_nal_unit_splitter.sv
// ----------------------------------------------------------------------------
// annexb_nal_unit_splitter
// cuts an annex b elementary stream packet into nal units at start codes
// ----------------------------------------------------------------------------
// in_* takes one stream byte per beat, in_tlast on the final byte of a packet.
// out_* gives one beat per byte that belongs to a nal unit, start code
// included; out_tuser flags the first start code byte, the header byte and
// the last beat caused by one input byte, out_tlast the packet's final beat.
// cfg_we/cfg_wdata set the codec: 0 h.264 (type = header[4:0]), 1 h.265
// (type = header[6:1]); write it only while the block is idle.
// throughput: one input byte per cycle while in_tready is high. a start code
// or a packet end releases up to five beats from one byte; these go into an
// 8-entry queue and leave at one beat per cycle while out_tready is high,
// in_tready drops while the queue holds more than three entries.
// a byte is held in a four-byte lookahead window until its role is known,
// then is written into the result queue and shows at out_* in queue order.
// reset (rst_n low, synchronous) empties window and queue and selects h.264.
// a stalled out_tready holds the head beat and fills the queue, after which
// in_tready goes low; nothing is dropped.
// ----------------------------------------------------------------------------
module annexb_nal_unit_splitter import anx_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,   // codec_mode
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // in_byte[7:0]
  input  logic        in_tlast,    // packet_last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,   // out_byte[7:0], start_code_length[10:8], nal_type[16:11]
  output logic [2:0]  out_tuser,   // nal_first[0], header_flag[1], run_last[2]
  output logic        out_tlast    // packet_end
);

  logic  codec_mode_r;
  logic  accept;
  logic  room;
  push_t push;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codec_mode_r <= CODEC_H264;
    end else if (cfg_we) begin
      codec_mode_r <= cfg_wdata;
    end
  end

  assign in_tready = room;
  assign accept    = in_tvalid && room;

  anx_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_byte (in_tdata),
    .in_last (in_tlast),
    .push    (push)
  );

  anx_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .codec_mode (codec_mode_r),
    .push       (push),
    .room       (room),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
